### rtl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants of the character LCD 8-bit write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned CfgAddrWidth      = 5;
  localparam int unsigned CfgDataWidth      = 32;

  localparam logic [7:0] InstrClear       = 8'h01;
  localparam logic [7:0] InstrHome        = 8'h02;
  localparam logic [7:0] Line1Base        = 8'h80;
  localparam logic [7:0] Line2Base        = 8'hC0;
  localparam logic [7:0] InstrFunctionSet = 8'b0011_1000;
  localparam logic [7:0] InstrDisplayOn   = 8'b0000_1111;
  localparam logic [7:0] InstrEntryMode   = 8'b0000_0110;

  localparam logic [9:0]  SetupWaitReset   = 10'd100;
  localparam logic [9:0]  PulseWaitReset   = 10'd200;
  localparam logic [9:0]  HoldWaitReset    = 10'd100;
  localparam logic [15:0] LongWaitReset    = 16'd1620;
  localparam logic [19:0] PowerupWaitReset = 20'd100000;

  typedef enum logic [2:0] {
    CmdWriteChar = 3'd0,
    CmdRawInstr  = 3'd1,
    CmdClear     = 3'd2,
    CmdHome      = 3'd3,
    CmdSetCursor = 3'd4,
    CmdInit      = 3'd5
  } lcdws_cmd_e;

  typedef enum logic [2:0] {
    RegSetupWait   = 3'd0,
    RegPulseWait   = 3'd1,
    RegHoldWait    = 3'd2,
    RegLongWait    = 3'd3,
    RegPowerupWait = 3'd4
  } lcdws_reg_e;

  typedef enum logic [1:0] {
    PhSetup,
    PhPulse,
    PhHold
  } lcdws_phase_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [1:0] cursor_line;
    logic [5:0] cursor_column;
  } lcdws_req_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_level;
    logic [7:0]  bus_byte;
    logic [19:0] hold_us;
    logic        last;
  } lcdws_seg_t;

  typedef struct packed {
    logic [9:0]  setup_wait_us;
    logic [9:0]  pulse_wait_us;
    logic [9:0]  hold_wait_us;
    logic [15:0] long_wait_us;
    logic [19:0] powerup_wait_us;
  } lcdws_cfg_t;

  typedef struct packed {
    logic       is_wait;
    logic       rs;
    logic [7:0] bus;
    logic       long_add;
    logic       last;
  } lcdws_job_t;

endpackage

### rtl/lcdws_stream_if.sv
// ----------------------------------------------------------------------------
// lcdws_stream_if
// Valid/ready channel that carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface lcdws_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/lcdws_cfg.sv
// ----------------------------------------------------------------------------
// lcdws_cfg
// Timing register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module lcdws_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcdws_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [lcdws_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [lcdws_pkg::CfgDataWidth-1:0]  prdata,
  output logic                                pready,
  output lcdws_pkg::lcdws_cfg_t               cfg_o
);
  import lcdws_pkg::*;

  lcdws_cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup_wait_us   <= SetupWaitReset;
      cfg_q.pulse_wait_us   <= PulseWaitReset;
      cfg_q.hold_wait_us    <= HoldWaitReset;
      cfg_q.long_wait_us    <= LongWaitReset;
      cfg_q.powerup_wait_us <= PowerupWaitReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSetupWait:   cfg_q.setup_wait_us   <= pwdata[9:0];
        RegPulseWait:   cfg_q.pulse_wait_us   <= pwdata[9:0];
        RegHoldWait:    cfg_q.hold_wait_us    <= pwdata[9:0];
        RegLongWait:    cfg_q.long_wait_us    <= pwdata[15:0];
        RegPowerupWait: cfg_q.powerup_wait_us <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSetupWait:   prdata = {22'd0, cfg_q.setup_wait_us};
      RegPulseWait:   prdata = {22'd0, cfg_q.pulse_wait_us};
      RegHoldWait:    prdata = {22'd0, cfg_q.hold_wait_us};
      RegLongWait:    prdata = {16'd0, cfg_q.long_wait_us};
      RegPowerupWait: prdata = {12'd0, cfg_q.powerup_wait_us};
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, expands each into jobs; one per cycle if queue not full.
// ----------------------------------------------------------------------------
module lcdws_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lcdws_stream_if.sink            req,
  input  logic                    q_full_i,
  output logic                    push_o,
  output lcdws_pkg::lcdws_job_t   job_o
);
  import lcdws_pkg::*;

  lcdws_req_t req_q, req_d;
  logic       busy_q, busy_d;
  logic [2:0] step_q, step_d;
  logic [2:0] num_jobs;
  logic       done;
  logic       accept;

  always_comb begin
    job_o    = '0;
    num_jobs = 3'd0;
    case (req_q.cmd)
      CmdWriteChar: begin
        num_jobs = 3'd1;
        job_o.rs = 1'b1;
        job_o.bus = req_q.data_byte;
      end
      CmdRawInstr: begin
        num_jobs = 3'd1;
        job_o.bus = req_q.data_byte;
      end
      CmdClear: begin
        num_jobs = 3'd1;
        job_o.bus = InstrClear;
        job_o.long_add = 1'b1;
      end
      CmdHome: begin
        num_jobs = 3'd1;
        job_o.bus = InstrHome;
        job_o.long_add = 1'b1;
      end
      CmdSetCursor: begin
        if (req_q.cursor_line == 2'd1) begin
          num_jobs = 3'd1;
          job_o.bus = Line1Base + {2'b00, req_q.cursor_column};
        end else if (req_q.cursor_line == 2'd2) begin
          num_jobs = 3'd1;
          job_o.bus = Line2Base + {2'b00, req_q.cursor_column};
        end
      end
      CmdInit: begin
        num_jobs = 3'd5;
        case (step_q)
          3'd0:    job_o.is_wait = 1'b1;
          3'd1:    job_o.bus = InstrFunctionSet;
          3'd2:    job_o.bus = InstrDisplayOn;
          3'd3: begin
            job_o.bus = InstrClear;
            job_o.long_add = 1'b1;
          end
          default: job_o.bus = InstrEntryMode;
        endcase
      end
      default: num_jobs = 3'd0;
    endcase
    job_o.last = (step_q == num_jobs - 3'd1);
  end

  assign push_o    = busy_q && (num_jobs != 3'd0) && !q_full_i;
  assign done      = busy_q && ((num_jobs == 3'd0) || (push_o && job_o.last));
  assign req.ready = !busy_q || done;
  assign accept    = req.valid && req.ready;

  always_comb begin
    req_d  = req_q;
    busy_d = busy_q;
    step_d = step_q;
    if (accept) begin
      req_d  = req.data;
      busy_d = 1'b1;
      step_d = 3'd0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (push_o) begin
      step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

### rtl/lcdws_queue.sv
// ----------------------------------------------------------------------------
// lcdws_queue
// Small FIFO of byte jobs between the front and the back part.
// ----------------------------------------------------------------------------
module lcdws_queue #(
  parameter int unsigned Depth = lcdws_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lcdws_pkg::lcdws_job_t push_job_i,
  input  logic                  pop_i,
  output lcdws_pkg::lcdws_job_t head_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import lcdws_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

  lcdws_job_t          mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### rtl/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Turns byte jobs into timed pin segments behind an output register.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcdws_pkg::lcdws_cfg_t cfg_i,
  input  lcdws_pkg::lcdws_job_t head_i,
  input  logic                  q_empty_i,
  output logic                  pop_o,
  lcdws_stream_if.source        seg
);
  import lcdws_pkg::*;

  lcdws_job_t   cur_q, cur_d;
  logic         cur_valid_q, cur_valid_d;
  lcdws_phase_e phase_q, phase_d;
  lcdws_seg_t   out_q, seg_d;
  logic         out_valid_q;
  logic         can_load, emit, final_ph, cur_take;

  assign can_load = !out_valid_q || seg.ready;
  assign emit     = cur_valid_q && can_load;
  assign final_ph = cur_q.is_wait || (phase_q == PhHold);
  assign cur_take = !cur_valid_q || (emit && final_ph);
  assign pop_o    = cur_take && !q_empty_i;

  always_comb begin
    seg_d.reg_select   = cur_q.rs;
    seg_d.bus_byte     = cur_q.bus;
    seg_d.enable_level = 1'b0;
    seg_d.last         = 1'b0;
    seg_d.hold_us      = '0;
    phase_d            = phase_q;
    if (cur_q.is_wait) begin
      seg_d.reg_select = 1'b0;
      seg_d.bus_byte   = '0;
      seg_d.hold_us    = cfg_i.powerup_wait_us;
      seg_d.last       = cur_q.last;
    end else begin
      unique case (phase_q)
        PhSetup: begin
          seg_d.hold_us = {10'd0, cfg_i.setup_wait_us};
          phase_d       = PhPulse;
        end
        PhPulse: begin
          seg_d.enable_level = 1'b1;
          seg_d.hold_us      = {10'd0, cfg_i.pulse_wait_us};
          phase_d            = PhHold;
        end
        PhHold: begin
          seg_d.hold_us = {10'd0, cfg_i.hold_wait_us}
                        + (cur_q.long_add ? {4'd0, cfg_i.long_wait_us} : 20'd0);
          seg_d.last    = cur_q.last;
          phase_d       = PhSetup;
        end
        default: phase_d = PhSetup;
      endcase
    end

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      cur_d       = head_i;
      cur_valid_d = 1'b1;
      phase_d     = PhSetup;
    end else if (cur_take) begin
      cur_valid_d = 1'b0;
    end else if (!emit) begin
      phase_d = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PhSetup;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
      if (can_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_q <= seg_d;
    end
  end

  assign seg.valid = out_valid_q;
  assign seg.data  = out_q;

endmodule

### rtl/char_lcd_8bit_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_8bit_write_sequencer_core
// Character LCD write sequencer for an 8-bit parallel bus.
// ----------------------------------------------------------------------------
// Each request transaction becomes a run of pin segments (RS, E, D7..D0 and a
// hold time in microseconds): three per byte sent, plus one power-up wait for
// the initialization request, and none for a set-cursor request on a line
// other than 1 or 2. The back part emits one segment per cycle while the
// output is ready. Requests are taken while earlier ones are still being
// sent, as long as the job queue between the front and back parts has room.
// The user must write the timing registers through the APB port only while
// the block is idle; the block itself does not enforce it.
module char_lcd_8bit_write_sequencer_core #(
  parameter int unsigned QueueDepth = lcdws_pkg::QueueDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lcdws_stream_if.sink                        req,
  lcdws_stream_if.source                      seg,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcdws_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [lcdws_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [lcdws_pkg::CfgDataWidth-1:0]  prdata,
  output logic                                pready
);
  import lcdws_pkg::*;

  lcdws_cfg_t cfg;
  lcdws_job_t push_job, head_job;
  logic       push, pop, q_full, q_empty;

  lcdws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdws_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  lcdws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  lcdws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .head_i    (head_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .seg       (seg)
  );

endmodule
